// ===== sv/hmr_pkg.sv =====
// hmr_pkg: shared widths, constants and item types for the histogram mean/RMS block.
// No dependencies; compiled first.
package hmr_pkg;

    // input item fields
    localparam int BIN_W       = 5;
    localparam int CNT_IN_W    = 16;
    localparam int SLOT_INPUTS = 4;

    // histogram shape
    localparam int NUM_BINS    = 32;
    localparam int NUM_SLOTS   = 4;
    localparam int COUNT_BITS  = 16;

    // default fraction bits of the mean/RMS outputs
    localparam int FRAC_BITS_DFLT = 16;

    // result and accumulator widths
    localparam int OUT_W = 21;
    localparam int ENT_W = 23;
    localparam int WS_W  = 27;
    localparam int SQ_W  = 32;

    localparam int QUEUE_DEPTH = 4;

    localparam int USED_SLOTS = (NUM_SLOTS < SLOT_INPUTS) ? NUM_SLOTS : SLOT_INPUTS;
    localparam int USED_CBITS = (COUNT_BITS < CNT_IN_W) ? COUNT_BITS : CNT_IN_W;
    localparam int CNT_W      = $clog2(USED_SLOTS * ((1 << USED_CBITS) - 1) + 1);
    localparam int BSQ_W      = 2 * BIN_W;

    // first bin index that is not accumulated (overflow bin and above)
    localparam logic [BIN_W:0] OVF_BIN = (BIN_W + 1)'(NUM_BINS - 1);

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // one classified bin on its way to the accumulator
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [BIN_W-1:0] bin;
        logic [BSQ_W-1:0] bin_sq;
        logic             last;
    } t_entry;

    // finished moments handed to the math unit
    typedef struct packed {
        logic             vld;
        logic [ENT_W-1:0] ent;
        logic [WS_W-1:0]  ws;
        logic [SQ_W-1:0]  sq;
    } t_mom_req;

endpackage

// ===== sv/hmr_in_if.sv =====
// hmr_in_if: valid/ready channel carrying one histogram bin item.
// Depends on hmr_pkg.
interface hmr_in_if;
    import hmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [BIN_W-1:0]    bin_index;
    logic [CNT_IN_W-1:0] count_slot0;
    logic [CNT_IN_W-1:0] count_slot1;
    logic [CNT_IN_W-1:0] count_slot2;
    logic [CNT_IN_W-1:0] count_slot3;
    logic                last_bin;

    modport source (
        output valid, bin_index, count_slot0, count_slot1, count_slot2, count_slot3,
               last_bin,
        input  ready
    );
    modport sink (
        input  valid, bin_index, count_slot0, count_slot1, count_slot2, count_slot3,
               last_bin,
        output ready
    );
endinterface

// ===== sv/hmr_out_if.sv =====
// hmr_out_if: valid/ready channel carrying one mean/RMS result item.
// Depends on hmr_pkg.
interface hmr_out_if;
    import hmr_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] mean_bin;
    logic [OUT_W-1:0] rms_bin;
    logic [ENT_W-1:0] entry_total;
    logic             no_entries;

    modport source (
        output valid, mean_bin, rms_bin, entry_total, no_entries,
        input  ready
    );
    modport sink (
        input  valid, mean_bin, rms_bin, entry_total, no_entries,
        output ready
    );
endinterface

// ===== sv/hmr_front.sv =====
// hmr_front: takes bin items, sums the slot counts, zeroes overflow bins, squares the index.
// Depends on hmr_pkg, hmr_in_if.
module hmr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hmr_in_if.sink          i_bin,
    output hmr_pkg::t_entry o_ent,
    output logic            o_ent_vld,
    input  logic            i_ent_rdy
);
    import hmr_pkg::*;

    logic                r_vld;
    t_entry              r_ent;
    t_entry              n_ent;
    logic [CNT_IN_W-1:0] slot [SLOT_INPUTS];
    logic [CNT_W-1:0]    cnt_sum;
    logic                skip;

    assign slot[0] = i_bin.count_slot0;
    assign slot[1] = i_bin.count_slot1;
    assign slot[2] = i_bin.count_slot2;
    assign slot[3] = i_bin.count_slot3;

    assign skip = ({1'b0, i_bin.bin_index} >= OVF_BIN);

    always_comb begin
        cnt_sum = '0;
        for (int i = 0; i < USED_SLOTS; i++) begin
            cnt_sum = cnt_sum + CNT_W'(slot[i][USED_CBITS-1:0]);
        end
    end

    always_comb begin
        n_ent.cnt    = skip ? '0 : cnt_sum;
        n_ent.bin    = i_bin.bin_index;
        n_ent.bin_sq = BSQ_W'(i_bin.bin_index) * BSQ_W'(i_bin.bin_index);
        n_ent.last   = i_bin.last_bin;
    end

    assign i_bin.ready = !r_vld || i_ent_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_bin.ready) begin
            r_vld <= i_bin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bin.valid && i_bin.ready) begin
            r_ent <= n_ent;
        end
    end

    assign o_ent     = r_ent;
    assign o_ent_vld = r_vld;

endmodule

// ===== sv/hmr_queue.sv =====
// hmr_queue: short flop FIFO decoupling the front end from the accumulator.
// Depends on hmr_pkg.
module hmr_queue #(
    parameter int DEPTH = hmr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hmr_pkg::t_entry i_ent,
    input  logic            i_push_vld,
    output logic            o_push_rdy,
    output hmr_pkg::t_entry o_ent,
    output logic            o_pop_vld,
    input  logic            i_pop_rdy
);
    import hmr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_rdy = (r_cnt != CW'(DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;
    assign o_ent      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

// ===== sv/hmr_accum.sv =====
// hmr_accum: saturating accumulation of entries, weighted and square-weighted sums.
// Depends on hmr_pkg. Hands the moments of a finished histogram to hmr_math.
module hmr_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmr_pkg::t_entry   i_ent,
    input  logic              i_ent_vld,
    output logic              o_ent_rdy,
    output hmr_pkg::t_mom_req o_req,
    input  logic              i_req_rdy
);
    import hmr_pkg::*;

    localparam int WP_W = CNT_W + BIN_W;
    localparam int SP_W = CNT_W + BSQ_W;

    logic [ENT_W-1:0] r_ent;
    logic [WS_W-1:0]  r_ws;
    logic [SQ_W-1:0]  r_sq;
    logic [ENT_W-1:0] n_ent;
    logic [WS_W-1:0]  n_ws;
    logic [SQ_W-1:0]  n_sq;
    logic [WP_W-1:0]  w_prod;
    logic [SP_W-1:0]  s_prod;
    logic [ENT_W:0]   e_sum;
    logic [WS_W:0]    w_sum;
    logic [SQ_W:0]    s_sum;
    logic             pop;

    assign w_prod = WP_W'(i_ent.cnt) * WP_W'(i_ent.bin);
    assign s_prod = SP_W'(i_ent.cnt) * SP_W'(i_ent.bin_sq);

    // carry out of each add means the all-ones limit was passed
    assign e_sum = (ENT_W + 1)'(r_ent) + (ENT_W + 1)'(i_ent.cnt);
    assign w_sum = (WS_W + 1)'(r_ws) + (WS_W + 1)'(w_prod);
    assign s_sum = (SQ_W + 1)'(r_sq) + (SQ_W + 1)'(s_prod);

    assign n_ent = e_sum[ENT_W] ? {ENT_W{1'b1}} : e_sum[ENT_W-1:0];
    assign n_ws  = w_sum[WS_W]  ? {WS_W{1'b1}}  : w_sum[WS_W-1:0];
    assign n_sq  = s_sum[SQ_W]  ? {SQ_W{1'b1}}  : s_sum[SQ_W-1:0];

    // a last bin waits until the math unit is free
    assign o_ent_rdy = !i_ent.last || i_req_rdy;
    assign pop       = i_ent_vld && o_ent_rdy;

    always_comb begin
        o_req.vld = i_ent_vld && i_ent.last;
        o_req.ent = n_ent;
        o_req.ws  = n_ws;
        o_req.sq  = n_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
            r_ws  <= '0;
            r_sq  <= '0;
        end else if (pop) begin
            if (i_ent.last) begin
                r_ent <= '0;
                r_ws  <= '0;
                r_sq  <= '0;
            end else begin
                r_ent <= n_ent;
                r_ws  <= n_ws;
                r_sq  <= n_sq;
            end
        end
    end

endmodule

// ===== sv/hmr_math.sv =====
// hmr_math: per-histogram mean and RMS: variance numerator, bit-serial square root,
// and one shared restoring divider. Depends on hmr_pkg, hmr_out_if.
module hmr_math #(
    parameter int FRAC_BITS = hmr_pkg::FRAC_BITS_DFLT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmr_pkg::t_mom_req i_req,
    output logic              o_req_rdy,
    hmr_out_if.source         o_res
);
    import hmr_pkg::*;

    localparam int NSQ_W = ENT_W + SQ_W;
    localparam int SS_W  = 2 * WS_W;
    localparam int DF_W  = (NSQ_W > SS_W) ? NSQ_W : SS_W;
    localparam int RW    = (DF_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RAD_W = 2 * RW;
    localparam int MN_W  = WS_W + FRAC_BITS;
    localparam int NW    = (MN_W > RW) ? MN_W : RW;
    localparam int CTW   = $clog2(NW);
    localparam int SRM_W = RW + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MDIV = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_RDIV = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       r_st;
    logic [ENT_W-1:0] r_ent;
    logic [WS_W-1:0]  r_ws;
    logic [SQ_W-1:0]  r_sq;
    logic [NSQ_W-1:0] r_nsq;
    logic [SS_W-1:0]  r_ss;
    logic [RAD_W-1:0] r_rad;
    logic [SRM_W-1:0] r_srem;
    logic [RW-1:0]    r_root;
    logic [ENT_W-1:0] r_drem;
    logic [NW-1:0]    r_quo;
    logic [CTW-1:0]   r_cnt;
    logic [OUT_W-1:0] r_mean;
    logic [OUT_W-1:0] r_rms;

    logic [DF_W-1:0]    diff;
    logic [ENT_W:0]     d_tr;
    logic               d_ge;
    logic [ENT_W-1:0]   d_rem_nx;
    logic [NW-1:0]      d_quo_nx;
    logic [OUT_W-1:0]   d_sat;
    logic [SRM_W+1:0]   s_tr;
    logic [SRM_W+1:0]   s_trial;
    logic               s_ge;
    logic [SRM_W+1:0]   s_sub;
    logic [RW-1:0]      s_root_nx;

    // n*sumsq - sum^2, clamped at zero
    assign diff = (DF_W'(r_nsq) > DF_W'(r_ss)) ? DF_W'(r_nsq) - DF_W'(r_ss) : '0;

    // restoring divide step, quotient bits shift in at the bottom of r_quo
    assign d_tr     = {r_drem, r_quo[NW-1]};
    assign d_ge     = (d_tr >= {1'b0, r_ent});
    assign d_rem_nx = d_ge ? ENT_W'(d_tr - {1'b0, r_ent}) : d_tr[ENT_W-1:0];
    assign d_quo_nx = {r_quo[NW-2:0], d_ge};
    assign d_sat    = (d_quo_nx > NW'(OUT_MAX)) ? OUT_MAX : d_quo_nx[OUT_W-1:0];

    // digit-by-digit square root step, two radicand bits per cycle
    assign s_tr      = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign s_trial   = {2'b00, r_root, 2'b01};
    assign s_ge      = (s_tr >= s_trial);
    assign s_sub     = s_tr - s_trial;
    assign s_root_nx = {r_root[RW-2:0], s_ge};

    assign o_req_rdy = (r_st == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (i_req.vld) begin
                        r_st <= (i_req.ent == '0) ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL:  r_st <= ST_DIFF;
                ST_DIFF: r_st <= ST_MDIV;
                ST_MDIV: begin
                    if (r_cnt == '0) begin
                        r_st <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == '0) begin
                        r_st <= ST_RDIV;
                    end
                end
                ST_RDIV: begin
                    if (r_cnt == '0) begin
                        r_st <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (o_res.ready) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                if (i_req.vld) begin
                    r_ent  <= i_req.ent;
                    r_ws   <= i_req.ws;
                    r_sq   <= i_req.sq;
                    r_mean <= '0;
                    r_rms  <= '0;
                end
            end
            ST_MUL: begin
                r_nsq <= NSQ_W'(r_ent) * NSQ_W'(r_sq);
                r_ss  <= SS_W'(r_ws) * SS_W'(r_ws);
            end
            ST_DIFF: begin
                r_rad  <= RAD_W'({diff, {(2 * FRAC_BITS){1'b0}}});
                r_quo  <= NW'({r_ws, {FRAC_BITS{1'b0}}});
                r_drem <= '0;
                r_cnt  <= CTW'(NW - 1);
            end
            ST_MDIV: begin
                r_quo  <= d_quo_nx;
                r_drem <= d_rem_nx;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_mean <= d_sat;
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= CTW'(RW - 1);
                end
            end
            ST_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_srem <= s_ge ? s_sub[SRM_W-1:0] : s_tr[SRM_W-1:0];
                r_root <= s_root_nx;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_quo  <= NW'(s_root_nx);
                    r_drem <= '0;
                    r_cnt  <= CTW'(NW - 1);
                end
            end
            ST_RDIV: begin
                r_quo  <= d_quo_nx;
                r_drem <= d_rem_nx;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_rms <= d_sat;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid       = (r_st == ST_DONE);
    assign o_res.mean_bin    = r_mean;
    assign o_res.rms_bin     = r_rms;
    assign o_res.entry_total = r_ent;
    assign o_res.no_entries  = (r_ent == '0);

endmodule

// ===== sv/histogram_mean_rms.sv =====
// histogram_mean_rms: mean and RMS bin index of a histogram streamed one bin per item.
// Bins are taken one per cycle while the queue has room; an item passes through the front
// register and the queue to the accumulator. A last bin then needs the math unit, whose
// serial divider (run twice) and root unit work out the result from the moments.
// Bins of the next histogram keep flowing meanwhile. Sync active-low reset clears all sums.
module histogram_mean_rms #(
    parameter int FRAC_BITS = hmr_pkg::FRAC_BITS_DFLT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hmr_in_if.sink    i_bin,
    hmr_out_if.source o_res
);
    import hmr_pkg::*;

    // front end -> queue
    t_entry   fe_ent;
    logic     fe_vld;
    logic     fe_rdy;

    // queue -> accumulator
    t_entry   q_ent;
    logic     q_vld;
    logic     q_rdy;

    // accumulator -> math unit
    t_mom_req mom_req;
    logic     mom_rdy;

    // classify each bin: slot sum, overflow-bin zeroing, index squared
    hmr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bin     (i_bin),
        .o_ent     (fe_ent),
        .o_ent_vld (fe_vld),
        .i_ent_rdy (fe_rdy)
    );

    // short FIFO so the front keeps taking bins while a last bin waits for math
    hmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ent      (fe_ent),
        .i_push_vld (fe_vld),
        .o_push_rdy (fe_rdy),
        .o_ent      (q_ent),
        .o_pop_vld  (q_vld),
        .i_pop_rdy  (q_rdy)
    );

    // saturating moment sums; cleared when a histogram is handed over
    hmr_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ent     (q_ent),
        .i_ent_vld (q_vld),
        .o_ent_rdy (q_rdy),
        .o_req     (mom_req),
        .i_req_rdy (mom_rdy)
    );

    // mean = (sum << F)/n, rms = isqrt((n*sumsq - sum^2) << 2F) / n; result held until taken
    hmr_math #(
        .FRAC_BITS (FRAC_BITS)
    ) u_math (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mom_req),
        .o_req_rdy (mom_rdy),
        .o_res     (o_res)
    );

endmodule

// ===== tb/tb_histogram_mean_rms.sv =====
// tb_histogram_mean_rms: self-checking bench for the histogram mean/RMS block.
// Streams directed and random histograms, predicts each result in-bench and checks it.
// Depends on hmr_pkg, hmr_in_if, hmr_out_if and histogram_mean_rms.
`timescale 1ns / 1ps

module tb_histogram_mean_rms;
    import hmr_pkg::*;

    // Fraction bits used by both the block and the bench's own predictor.
    localparam int FRAC = FRAC_BITS_DFLT;

    // Random part size, end-of-run tail, hard cycle limit, gap and report caps.
    // The tail covers a last bin's trip through the math unit, with margin.
    localparam int RANDOM_ITEMS = 1450;
    localparam int TAIL_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_WAIT     = 18;
    localparam int MAX_REPORTS  = 10;

    // Saturation limits of the three accumulators and the count mask.
    localparam logic [63:0] ENT_LIM  = (64'd1 << ENT_W) - 1;
    localparam logic [63:0] WS_LIM   = (64'd1 << WS_W) - 1;
    localparam logic [63:0] SQ_LIM   = (64'd1 << SQ_W) - 1;
    localparam logic [63:0] CNT_MASK = (64'd1 << USED_CBITS) - 1;

    // Sender pacing styles, redrawn every few dozen items.
    typedef enum int {
        PACE_FULL   = 0,   // no gaps at all
        PACE_RANDOM = 1,   // random gap before every item
        PACE_SPARSE = 2    // mostly back-to-back, an occasional long gap
    } t_pace;

    // Count patterns for one histogram.
    typedef enum int {
        CNT_ANY   = 0,     // full 16-bit random
        CNT_TINY  = 1,     // 0..15
        CNT_SPOTS = 2,     // mostly zero, a few small
        CNT_HEAVY = 3      // mostly all-ones, to drive the sums into saturation
    } t_cnt_style;

    // One bin item as queued for the driver. 'drain' holds it back until every
    // outstanding result has been returned.
    typedef struct packed {
        logic [BIN_W-1:0]                     bin;
        logic [SLOT_INPUTS-1:0][CNT_IN_W-1:0] cnt;
        logic                                 last;
        logic                                 drain;
    } t_bin_item;

    // One expected mean/RMS result.
    typedef struct packed {
        logic [OUT_W-1:0] mean_bin;
        logic [OUT_W-1:0] rms_bin;
        logic [ENT_W-1:0] entry_total;
        logic             no_entries;
    } t_moments;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmr_in_if  bin_ch ();
    hmr_out_if res_ch ();

    histogram_mean_rms #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (bin_ch),
        .o_res   (res_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_bin_item pending_bins[$];       // stimulus not yet presented
    t_moments  expected_moments[$];   // predicted results, oldest first

    // Running sums of the histogram currently being streamed (bench copy).
    logic [63:0] acc_entries;
    logic [63:0] acc_wsum;
    logic [63:0] acc_sqsum;

    int hist_closed   = 0;   // histograms closed by an accepted last bin (driver side)
    int hist_reported = 0;   // results accepted from the block (monitor side, NBA)
    int mismatches    = 0;
    int cycle_count   = 0;

    t_bin_item cur_item;
    int        gap_left      = 0;
    int        items_shown   = 0;
    t_pace     send_pace     = PACE_RANDOM;
    int        stall_left    = 0;
    t_pace     recv_pace     = PACE_RANDOM;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] sat_sum(input logic [63:0] acc, input logic [63:0] add,
                                            input logic [63:0] lim);
        if (add >= lim || acc > lim - add)
            return lim;
        return acc + add;
    endfunction

    // Largest r that fits the output with (r*n)^2 <= d * 2^(2*FRAC), i.e.
    // floor(sqrt(d) * 2^FRAC / n). Bit-serial search, MSB first.
    function automatic logic [OUT_W-1:0] root_scaled(input logic [63:0] d,
                                                     input logic [63:0] n);
        logic [127:0]     target;
        logic [127:0]     q;
        logic [OUT_W-1:0] r;
        logic [OUT_W-1:0] c;
        int               k;
        target = {64'd0, d} << (2 * FRAC);
        r = '0;
        for (k = OUT_W - 1; k >= 0; k--) begin
            c = r | (OUT_W'(1) << k);
            q = 128'(c) * 128'(n);
            if (q * q <= target)
                r = c;
        end
        return r;
    endfunction

    // Fold one accepted bin into the running sums; on a last bin, work out the
    // mean and RMS, queue them and start a fresh histogram.
    task automatic accumulate_bin(input t_bin_item it);
        logic [63:0] total;
        logic [63:0] bin64;
        logic [63:0] quot;
        logic [63:0] nsq;
        logic [63:0] ssq;
        logic [63:0] diff;
        t_moments    m;
        int          s;
        bin64 = 64'(it.bin);
        // overflow bin (and anything above) contributes nothing
        if (bin64 < 64'(NUM_BINS - 1)) begin
            total = '0;
            for (s = 0; s < USED_SLOTS; s++)
                total += 64'(it.cnt[s]) & CNT_MASK;
            acc_entries = sat_sum(acc_entries, total, ENT_LIM);
            acc_wsum    = sat_sum(acc_wsum, total * bin64, WS_LIM);
            acc_sqsum   = sat_sum(acc_sqsum, total * bin64 * bin64, SQ_LIM);
        end
        if (it.last) begin
            m = '0;
            m.entry_total = ENT_W'(acc_entries);
            m.no_entries  = (acc_entries == 0);
            if (acc_entries != 0) begin
                quot = (acc_wsum << FRAC) / acc_entries;
                m.mean_bin = (quot > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(quot);
                // variance numerator n*sumsq - sum^2, clamped at zero
                nsq  = acc_entries * acc_sqsum;
                ssq  = acc_wsum * acc_wsum;
                diff = (nsq > ssq) ? nsq - ssq : 64'd0;
                m.rms_bin = root_scaled(diff, acc_entries);
            end
            expected_moments.insert(expected_moments.size(), m);
            hist_closed++;
            acc_entries = '0;
            acc_wsum    = '0;
            acc_sqsum   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_wait(input t_pace pace);
        unique case (pace)
            PACE_FULL:   return 0;
            PACE_RANDOM: return $urandom_range(0, MAX_WAIT);
            default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    function automatic logic [CNT_IN_W-1:0] draw_count(input t_cnt_style style);
        unique case (style)
            CNT_ANY:   return CNT_IN_W'($urandom);
            CNT_TINY:  return CNT_IN_W'($urandom_range(0, 15));
            CNT_SPOTS: return ($urandom_range(0, 3) == 0) ? CNT_IN_W'($urandom_range(0, 255))
                                                           : '0;
            default:   return ($urandom_range(0, 3) != 0) ? {CNT_IN_W{1'b1}}
                                                           : CNT_IN_W'($urandom);
        endcase
    endfunction

    task automatic push_bin(input logic [BIN_W-1:0] b,
                            input logic [SLOT_INPUTS-1:0][CNT_IN_W-1:0] c,
                            input logic last, input logic drain);
        t_bin_item it;
        it.bin   = b;
        it.cnt   = c;
        it.last  = last;
        it.drain = drain;
        pending_bins.insert(pending_bins.size(), it);
    endtask

    task automatic push_random_bin(input logic [BIN_W-1:0] b, input t_cnt_style style,
                                   input logic last, input logic drain);
        logic [SLOT_INPUTS-1:0][CNT_IN_W-1:0] c;
        int                                   s;
        for (s = 0; s < SLOT_INPUTS; s++)
            c[s] = draw_count(style);
        push_bin(b, c, last, drain);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued bins with random gaps. The predictor runs on
    // each item at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bins
        t_bin_item nxt;
        logic      free;
        if (!i_rst_n) begin
            bin_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            free = !bin_ch.valid || bin_ch.ready;
            if (bin_ch.valid && bin_ch.ready)
                accumulate_bin(cur_item);
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    bin_ch.valid <= 1'b0;
                end else if (pending_bins.size() != 0 &&
                             (!pending_bins[0].drain || hist_reported == hist_closed)) begin
                    // a drain item only goes out once the block has returned everything
                    nxt = pending_bins.pop_front();
                    cur_item = nxt;
                    bin_ch.valid       <= 1'b1;
                    bin_ch.bin_index   <= nxt.bin;
                    bin_ch.count_slot0 <= nxt.cnt[0];
                    bin_ch.count_slot1 <= nxt.cnt[1];
                    bin_ch.count_slot2 <= nxt.cnt[2];
                    bin_ch.count_slot3 <= nxt.cnt[3];
                    bin_ch.last_bin    <= nxt.last;
                    if (items_shown % 40 == 0)
                        send_pace = t_pace'($urandom_range(0, 2));
                    items_shown++;
                    // gap that precedes the following item
                    gap_left = draw_wait(send_pace);
                end else begin
                    bin_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure on the result side and in-order compare.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_moments want;
        int       stall_v;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            stall_v = stall_left;
            if (res_ch.valid && res_ch.ready) begin
                hist_reported <= hist_reported + 1;
                if (expected_moments.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: mean %0d rms %0d total %0d empty %0d",
                                 res_ch.mean_bin, res_ch.rms_bin, res_ch.entry_total,
                                 res_ch.no_entries);
                end else begin
                    want = expected_moments.pop_front();
                    if (res_ch.mean_bin !== want.mean_bin ||
                        res_ch.rms_bin !== want.rms_bin ||
                        res_ch.entry_total !== want.entry_total ||
                        res_ch.no_entries !== want.no_entries) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d mismatch: mean exp %0d got %0d, ",
                                      "rms exp %0d got %0d, total exp %0d got %0d, ",
                                      "empty exp %0d got %0d"},
                                     hist_reported, want.mean_bin, res_ch.mean_bin,
                                     want.rms_bin, res_ch.rms_bin,
                                     want.entry_total, res_ch.entry_total,
                                     want.no_entries, res_ch.no_entries);
                    end
                end
                if (hist_reported % 8 == 7)
                    recv_pace = t_pace'($urandom_range(0, 2));
                stall_v = draw_wait(recv_pace);
            end else if (stall_v > 0) begin
                stall_v--;
            end
            stall_left = stall_v;
            res_ch.ready <= (stall_v == 0);
        end
    end

    // Hard limit on run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("histogram_mean_rms test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run_ctl
        int         directed;
        int         shape;
        int         len;
        int         j;
        int         nhist;
        logic       hold;
        t_cnt_style style;

        // known values on every block input before the first edge
        i_rst_n            = 1'b0;
        bin_ch.valid       = 1'b0;
        bin_ch.bin_index   = '0;
        bin_ch.count_slot0 = '0;
        bin_ch.count_slot1 = '0;
        bin_ch.count_slot2 = '0;
        bin_ch.count_slot3 = '0;
        bin_ch.last_bin    = 1'b0;
        res_ch.ready       = 1'b0;
        acc_entries        = '0;
        acc_wsum           = '0;
        acc_sqsum          = '0;

        // --- directed histograms ---
        // lowest bin, all slots full: mean and RMS both zero
        push_bin(5'd0, {4{16'hFFFF}}, 1'b1, 1'b0);
        // highest counted bin, all slots full: mean 30, RMS zero
        push_bin(5'd30, {4{16'hFFFF}}, 1'b1, 1'b0);
        // only the overflow bin: treated as an empty histogram
        push_bin(5'd31, {4{16'hFFFF}}, 1'b1, 1'b0);
        // all counts zero: empty histogram
        push_bin(5'd5, {4{16'h0000}}, 1'b1, 1'b0);
        // one entry at each end: mean 15, RMS 15
        push_bin(5'd0, {16'h0000, 16'h0000, 16'h0000, 16'h0001}, 1'b0, 1'b0);
        push_bin(5'd30, {16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 1'b0);
        // overflow bins around a single real bin, last flag on the overflow bin
        push_bin(5'd31, {4{16'hFFFF}}, 1'b0, 1'b0);
        push_bin(5'd7, {16'h0000, 16'h0000, 16'h0003, 16'h0000}, 1'b0, 1'b0);
        push_bin(5'd31, {4{16'hFFFF}}, 1'b1, 1'b0);
        // three neighbors, one per slot: fractional RMS, truncated
        push_bin(5'd1, {16'h0000, 16'h0000, 16'h0000, 16'h0001}, 1'b0, 1'b0);
        push_bin(5'd2, {16'h0000, 16'h0000, 16'h0001, 16'h0000}, 1'b0, 1'b0);
        push_bin(5'd3, {16'h0000, 16'h0001, 16'h0000, 16'h0000}, 1'b1, 1'b0);
        // repeated bin
        push_bin(5'd12, {4{16'h8000}}, 1'b0, 1'b0);
        push_bin(5'd12, {16'h0001, 16'h7FFF, 16'h0000, 16'h8000}, 1'b1, 1'b0);
        // alternating bit patterns in bin index and counts
        push_bin(5'd21, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, 1'b0);
        push_bin(5'd10, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1, 1'b0);
        directed = pending_bins.size();

        // --- random histograms ---
        // Well-formed sweeps over every bin in two of five; the rest short, empty,
        // sparse and saturating histograms. The first random histogram and
        // about one in twelve after it wait for the block to drain first.
        nhist = 0;
        while (pending_bins.size() < directed + RANDOM_ITEMS) begin
            hold  = (nhist == 0) || ($urandom_range(0, 11) == 0);
            shape = $urandom_range(0, 19);
            style = t_cnt_style'($urandom_range(0, 3));
            if (shape < 8) begin
                // full sweep, bin 0 up to the overflow bin, last on the overflow bin
                for (j = 0; j < NUM_BINS; j++)
                    push_random_bin(BIN_W'(j), style, j == NUM_BINS - 1, hold && j == 0);
            end else if (shape < 13) begin
                // short run of arbitrary bins in any order
                len = $urandom_range(1, 12);
                for (j = 0; j < len; j++)
                    push_random_bin(BIN_W'($urandom_range(0, NUM_BINS - 1)), style,
                                    j == len - 1, hold && j == 0);
            end else if (shape < 15) begin
                // nothing to count: zero counts, or overflow bin only
                len = $urandom_range(1, 4);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 1) == 0)
                        push_bin(BIN_W'($urandom_range(0, NUM_BINS - 1)), '0,
                                 j == len - 1, hold && j == 0);
                    else
                        push_random_bin(BIN_W'(NUM_BINS - 1), CNT_ANY,
                                        j == len - 1, hold && j == 0);
                end
            end else if (shape < 17) begin
                // long run of high bins near full scale: sums saturate
                len = $urandom_range(20, 36);
                for (j = 0; j < len; j++)
                    push_random_bin(BIN_W'($urandom_range(NUM_BINS - 8, NUM_BINS - 1)),
                                    CNT_HEAVY, j == len - 1, hold && j == 0);
            end else begin
                // sparse histogram with few entries
                len = $urandom_range(1, 8);
                for (j = 0; j < len; j++)
                    push_random_bin(BIN_W'($urandom_range(0, NUM_BINS - 1)), CNT_SPOTS,
                                    j == len - 1, hold && j == 0);
            end
            nhist++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample away from the active edge: all sent and every result back
        do
            @(negedge i_clk);
        while (pending_bins.size() != 0 || bin_ch.valid || hist_reported != hist_closed);

        // let any stray result surface before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_moments.size() == 0)
            $display("histogram_mean_rms test passed");
        else
            $display("histogram_mean_rms test failed");
        $finish;
    end

endmodule

// ===== histogram_mean_rms.f =====
sv/hmr_pkg.sv
sv/hmr_in_if.sv
sv/hmr_out_if.sv
sv/hmr_front.sv
sv/hmr_queue.sv
sv/hmr_accum.sv
sv/hmr_math.sv
sv/histogram_mean_rms.sv
tb/tb_histogram_mean_rms.sv
